// ===== rtl/free_region_labeler_macros.svh =====
// Assertion macros shared by the labeler RTL
`ifndef FREE_REGION_LABELER_MACROS_SVH
`define FREE_REGION_LABELER_MACROS_SVH

// Check a property on every clock edge outside reset
`define FRL_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define FRL_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/frl_pkg.sv =====
// Shared types and register indexes of the free region labeler
package frl_pkg;

  localparam int unsigned CFG_DATA_W = 9;

  localparam logic CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic CFG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic        command;
    logic [15:0] label_in;
    logic        is_line;
  } in_item_t;

  typedef struct packed {
    logic [15:0] label_out;
    logic        last;
    logic [15:0] highest_label;
    logic        overflow;
  } out_item_t;

endpackage

// ===== rtl/frl_ram.sv =====
// Generic single write, single read RAM with registered read data
module frl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/frl_queue.sv =====
// Short queue that decouples the two sides of the labeler
module frl_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wptr_q, rptr_q;
  logic [PW:0]      cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// ===== rtl/frl_engine.sv =====
// Back end: pixel stores, labelling sequencer and read-out
module frl_engine #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned LABEL_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_index_i,
  input  logic [frl_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  frl_pkg::in_item_t            req_i,
  input  logic                         req_empty_i,
  output logic                         req_pop_o,
  input  logic                         res_full_i,
  output logic                         res_push_o,
  output frl_pkg::out_item_t           res_o
);
  import frl_pkg::*;
  `include "free_region_labeler_macros.svh"

  localparam int unsigned CAP = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW  = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int unsigned CW  = $clog2(CAP + 1);
  localparam int unsigned XW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned W_RST = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
  localparam int unsigned H_RST = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
  localparam logic [LABEL_BITS-1:0] TOP = '1;

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_RDW  = 10'b0000000010,
    ST_MAXS = 10'b0000000100,
    ST_MAXW = 10'b0000001000,
    ST_SCAN = 10'b0000010000,
    ST_SCHK = 10'b0000100000,
    ST_POP  = 10'b0001000000,
    ST_POPW = 10'b0010000000,
    ST_NBR  = 10'b0100000000,
    ST_NCHK = 10'b1000000000
  } state_e;

  state_e                state_q, state_d;
  logic [XW-1:0]         w_q, w_d;
  logic [YW-1:0]         h_q, h_d;
  logic [CW-1:0]         ld_q, ld_d, rd_q, rd_d;
  logic [CW-1:0]         s_q, s_d, depth_q, depth_d;
  logic [XW-1:0]         x_q, x_d, px_q, px_d, qx_q, qx_d;
  logic [AW-1:0]         p_q, p_d, q_q, q_d;
  logic [1:0]            k_q, k_d;
  logic                  dv_q, dv_d, ovf_q, ovf_d;
  logic [LABEL_BITS-1:0] next_q, next_d, m_q, m_d, id_q, id_d;

  logic [XW+YW-1:0]      prod;
  logic [CW-1:0]         n;
  logic                  lbl_we, stk_we;
  logic [AW-1:0]         lbl_waddr, lbl_raddr, stk_waddr, stk_raddr;
  logic [LABEL_BITS-1:0] lbl_wdata, lbl_rdata, m_upd, new_id, next_inc;
  logic                  wall_wdata, wall_rdata, free_px, new_ovf;
  logic [AW+XW-1:0]      stk_wdata, stk_rdata;
  logic [CW:0]           pc, wc, nc;
  logic                  nb_ok;
  logic [AW-1:0]         nb_q;
  logic [XW-1:0]         nb_x;
  logic                  s_last;
  logic [CW-1:0]         s_nxt;
  logic [XW-1:0]         x_nxt;
  logic [XW-1:0]         cfg_w;
  logic [YW-1:0]         cfg_h;

  frl_ram #(.WIDTH(LABEL_BITS), .DEPTH(CAP)) u_label_ram (
    .clk_i, .we_i(lbl_we), .waddr_i(lbl_waddr), .wdata_i(lbl_wdata),
    .raddr_i(lbl_raddr), .rdata_o(lbl_rdata)
  );

  frl_ram #(.WIDTH(1), .DEPTH(CAP)) u_wall_ram (
    .clk_i, .we_i(lbl_we), .waddr_i(lbl_waddr), .wdata_i(wall_wdata),
    .raddr_i(lbl_raddr), .rdata_o(wall_rdata)
  );

  frl_ram #(.WIDTH(AW + XW), .DEPTH(CAP)) u_stack_ram (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  assign prod    = (XW+YW)'(w_q) * (XW+YW)'(h_q);
  assign n       = CW'(prod);
  assign free_px = (lbl_rdata == '0) && !wall_rdata;
  assign m_upd   = (dv_q && (lbl_rdata > m_q)) ? lbl_rdata : m_q;
  assign new_ovf = (next_q >= TOP);
  assign new_id  = new_ovf ? TOP : next_q + 1'b1;
  assign next_inc = new_ovf ? next_q : next_q + 1'b1;
  assign s_last  = (s_q + 1'b1 == n);
  assign s_nxt   = s_q + 1'b1;
  assign x_nxt   = (x_q + 1'b1 == w_q) ? '0 : x_q + 1'b1;

  assign cfg_w = (cfg_data_i == '0) ? XW'(1) :
                 (int'(cfg_data_i) > MAX_WIDTH) ? XW'(MAX_WIDTH) : XW'(cfg_data_i);
  assign cfg_h = (cfg_data_i == '0) ? YW'(1) :
                 (int'(cfg_data_i) > MAX_HEIGHT) ? YW'(MAX_HEIGHT) : YW'(cfg_data_i);

  // neighbour k of the popped pixel: left, right, up, down
  always_comb begin
    pc    = (CW+1)'(p_q);
    wc    = (CW+1)'(w_q);
    nc    = (CW+1)'(n);
    nb_ok = 1'b0;
    nb_q  = p_q;
    nb_x  = px_q;
    case (k_q)
      2'd0: begin
        nb_ok = (px_q != '0);
        nb_q  = p_q - 1'b1;
        nb_x  = px_q - 1'b1;
      end
      2'd1: begin
        nb_ok = ((CW+1)'(px_q) + 1'b1 < wc);
        nb_q  = p_q + 1'b1;
        nb_x  = px_q + 1'b1;
      end
      2'd2: begin
        nb_ok = (pc >= wc);
        nb_q  = AW'(pc - wc);
      end
      2'd3: begin
        nb_ok = (pc + wc < nc);
        nb_q  = AW'(pc + wc);
      end
      default: nb_ok = 1'b0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    w_d = w_q;  h_d = h_q;
    ld_d = ld_q;  rd_d = rd_q;
    s_d = s_q;  x_d = x_q;  depth_d = depth_q;
    p_d = p_q;  px_d = px_q;  q_d = q_q;  qx_d = qx_q;  k_d = k_q;
    dv_d = dv_q;  ovf_d = ovf_q;  next_d = next_q;  m_d = m_q;  id_d = id_q;
    req_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o.label_out     = 16'(lbl_rdata);
    res_o.last          = (rd_q + 1'b1 == n);
    res_o.highest_label = 16'(next_q);
    res_o.overflow      = ovf_q;
    lbl_we     = 1'b0;
    lbl_waddr  = s_q[AW-1:0];
    lbl_wdata  = id_q;
    wall_wdata = 1'b0;
    lbl_raddr  = s_q[AW-1:0];
    stk_we     = 1'b0;
    stk_waddr  = depth_q[AW-1:0];
    stk_wdata  = {q_q, qx_q};
    stk_raddr  = AW'(depth_q - 1'b1);

    case (state_q)
      ST_IDLE: begin
        lbl_raddr = rd_q[AW-1:0];
        if (!req_empty_i) begin
          if (!req_i.command) begin
            req_pop_o = 1'b1;
            if (ld_q < n) begin
              lbl_we     = 1'b1;
              lbl_waddr  = ld_q[AW-1:0];
              lbl_wdata  = LABEL_BITS'(req_i.label_in);
              wall_wdata = req_i.is_line;
              ld_d       = ld_q + 1'b1;
              if (ld_q + 1'b1 == n) begin
                s_d = '0;  m_d = '0;  dv_d = 1'b0;
                state_d = ST_MAXS;
              end
            end
          end else if ((ld_q == n) && (rd_q < n)) begin
            if (!res_full_i) begin
              req_pop_o = 1'b1;
              state_d   = ST_RDW;
            end
          end else begin
            req_pop_o = 1'b1;
          end
        end
      end
      ST_RDW: begin
        res_push_o = 1'b1;
        if (rd_q + 1'b1 == n) begin
          rd_d = '0;
          ld_d = '0;
        end else begin
          rd_d = rd_q + 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_MAXS: begin
        m_d  = m_upd;
        dv_d = 1'b1;
        s_d  = s_nxt;
        if (s_last) begin
          state_d = ST_MAXW;
        end
      end
      ST_MAXW: begin
        next_d  = m_upd;
        ovf_d   = 1'b0;
        s_d     = '0;
        x_d     = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        state_d = ST_SCHK;
      end
      ST_SCHK: begin
        if (free_px) begin
          lbl_we    = 1'b1;
          lbl_wdata = new_id;
          id_d      = new_id;
          next_d    = next_inc;
          if (new_ovf) begin
            ovf_d = 1'b1;
          end
          stk_we    = 1'b1;
          stk_wdata = {s_q[AW-1:0], x_q};
          depth_d   = CW'(1);
          state_d   = ST_POP;
        end else if (s_last) begin
          state_d = ST_IDLE;
        end else begin
          s_d = s_nxt;  x_d = x_nxt;
          state_d = ST_SCAN;
        end
      end
      ST_POP: begin
        if (depth_q == '0) begin
          if (s_last) begin
            state_d = ST_IDLE;
          end else begin
            s_d = s_nxt;  x_d = x_nxt;
            state_d = ST_SCAN;
          end
        end else begin
          depth_d = depth_q - 1'b1;
          state_d = ST_POPW;
        end
      end
      ST_POPW: begin
        {p_d, px_d} = stk_rdata;
        k_d     = '0;
        state_d = ST_NBR;
      end
      ST_NBR: begin
        lbl_raddr = nb_q;
        q_d  = nb_q;
        qx_d = nb_x;
        if (nb_ok) begin
          state_d = ST_NCHK;
        end else if (k_q == 2'd3) begin
          state_d = ST_POP;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_NCHK: begin
        if (free_px) begin
          lbl_we    = 1'b1;
          lbl_waddr = q_q;
          stk_we    = 1'b1;
          depth_d   = depth_q + 1'b1;
        end
        if (k_q == 2'd3) begin
          state_d = ST_POP;
        end else begin
          k_d = k_q + 1'b1;
          state_d = ST_NBR;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (cfg_we_i) begin
      if (cfg_index_i == CFG_IMAGE_WIDTH) begin
        w_d = cfg_w;
      end else begin
        h_d = cfg_h;
      end
      ld_d = '0;
      rd_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      w_q     <= XW'(W_RST);
      h_q     <= YW'(H_RST);
      ld_q    <= '0;
      rd_q    <= '0;
      depth_q <= '0;
      next_q  <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      w_q     <= w_d;
      h_q     <= h_d;
      ld_q    <= ld_d;
      rd_q    <= rd_d;
      depth_q <= depth_d;
      next_q  <= next_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q  <= s_d;   x_q  <= x_d;
    p_q  <= p_d;   px_q <= px_d;
    q_q  <= q_d;   qx_q <= qx_d;
    k_q  <= k_d;   dv_q <= dv_d;
    m_q  <= m_d;   id_q <= id_d;
  end

  `FRL_ASSERT(a_read_after_label, clk_i, rst_ni, (rd_q != '0) |-> (ld_q == n), "read before labelling")
  `FRL_ASSERT(a_stack_in_flood, clk_i, rst_ni, (depth_q != '0) |-> (state_q == ST_POP || state_q == ST_POPW || state_q == ST_NBR || state_q == ST_NCHK), "stack left non-empty")
  `FRL_ASSERT(a_push_from_read, clk_i, rst_ni, res_push_o |-> $past(req_pop_o && req_i.command), "result without read request")

endmodule

// ===== rtl/free_region_labeler.sv =====
// Top level of the free region labeler: request queue, labelling engine, result queue
//
//  channel  | handshake          | payload
//  request  | push / full        | in_item_i  (command, label_in, is_line)
//  result   | empty / pop        | out_item_o (label_out, last, highest_label, overflow)
//  config   | cfg_we_i           | cfg_index_i, cfg_data_i
//
// A load request is taken in ST_IDLE; a read request passes through ST_IDLE and then ST_RDW.
// The last load of an image starts labelling: a maximum scan over all pixels, then a scan
// of every pixel with a flood fill from each free one found, all on one label RAM port.
// No request is taken from the queue while labelling runs; a full result queue stalls reads.
// Reset clears counters and control; the pixel stores are not cleared.
module free_region_labeler #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned LABEL_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  frl_pkg::in_item_t              in_item_i,
  output logic                           empty,
  input  logic                           pop,
  output frl_pkg::out_item_t             out_item_o,
  input  logic                           cfg_we_i,
  input  logic                           cfg_index_i,
  input  logic [frl_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import frl_pkg::*;

  localparam int unsigned IW = $bits(in_item_t);
  localparam int unsigned OW = $bits(out_item_t);

  logic [IW-1:0] req_bits;
  logic [OW-1:0] res_bits, out_bits;
  in_item_t      req;
  out_item_t     res;
  logic          req_empty, req_pop, res_full, res_push;

  frl_queue #(.WIDTH(IW), .DEPTH(2)) u_req_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(in_item_i), .full_o(full),
    .pop_i(req_pop), .data_o(req_bits), .empty_o(req_empty)
  );

  assign req      = in_item_t'(req_bits);
  assign res_bits = res;

  frl_engine #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT), .LABEL_BITS(LABEL_BITS)
  ) u_engine (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .req_i(req), .req_empty_i(req_empty), .req_pop_o(req_pop),
    .res_full_i(res_full), .res_push_o(res_push), .res_o(res)
  );

  frl_queue #(.WIDTH(OW), .DEPTH(2)) u_res_queue (
    .clk_i, .rst_ni, .push_i(res_push), .data_i(res_bits), .full_o(res_full),
    .pop_i(pop), .data_o(out_bits), .empty_o(empty)
  );

  assign out_item_o = out_item_t'(out_bits);

endmodule
